[design/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/epcal_pkg.sv]
package epcal_pkg;

    localparam int TW = 31;

    localparam logic [6:0] YEAR_OFFSET = 7'd2;
    localparam logic [6:0] YEAR_LIMIT  = 7'd99;
    localparam logic [3:0] LAST_MONTH  = 4'd12;

    localparam logic [TW-1:0] SECS_PER_DAY  = TW'(86400);
    localparam logic [TW-1:0] SECS_PER_HOUR = TW'(3600);
    localparam logic [TW-1:0] SECS_PER_MIN  = TW'(60);

    localparam logic [TW-1:0] SECS_D31 = TW'(31 * 86400);
    localparam logic [TW-1:0] SECS_D30 = TW'(30 * 86400);
    localparam logic [TW-1:0] SECS_D29 = TW'(29 * 86400);
    localparam logic [TW-1:0] SECS_D28 = TW'(28 * 86400);

    localparam logic [TW-1:0] SECS_LEAP_YEAR = TW'(366 * 86400);
    localparam logic [TW-1:0] SECS_YEAR      = TW'(365 * 86400);

    // Bit positions for the binary splits of the month remainder.
    localparam logic [2:0] DAY_TOP_BIT  = 3'd4;
    localparam logic [2:0] HOUR_TOP_BIT = 3'd4;
    localparam logic [2:0] MIN_TOP_BIT  = 3'd5;

    typedef struct packed {
        logic [6:0] year_count;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
    } epcal_result_t;

    function automatic logic [TW-1:0] month_secs(input logic [3:0] mon, input logic leap);
        logic [TW-1:0] s;
        case (mon) inside
            4'd2:                     s = leap ? SECS_D29 : SECS_D28;
            4'd4, 4'd6, 4'd9, 4'd11:  s = SECS_D30;
            default:                  s = SECS_D31;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] mod7(input logic [4:0] d);
        logic [4:0] r;
        r = d;
        for (int i = 0; i < 4; i++) begin
            if (r >= 5'd7) begin
                r = r - 5'd7;
            end
        end
        return r[2:0];
    endfunction

endpackage

[design/epoch_seconds_to_calendar_top.sv]
// Converts a count of seconds since the epoch into calendar fields.
// Input channel: in_valid/in_ready with epoch_seconds; a transaction takes
// place when both are high at a rising edge of clk.
// Output channel: out_valid/out_ready with year_count, month, day_of_month,
// hour, minute, second and weekday, one result transaction per input.
// All steps share a single compare-subtract unit: one year or month per
// cycle, then binary splits of the remainder into days, hours and minutes.
// in_ready is high only while the converter is idle, so a new input is taken
// only once the previous result has been loaded into the output register.
// The result lands in an output register; the converter goes idle again
// once it is loaded, so a new item can start while out_ready is low.
// A second finished result waits in the converter until the output
// register is taken.
// Reset (rst_n low, asynchronous) returns the converter to idle and empties
// the output register.
`include "assert_macros.svh"

module epoch_seconds_to_calendar_top
    import epcal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [30:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  year_count,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [2:0]  weekday
);

    logic          idle;
    logic          res_valid;
    logic          load;
    epcal_result_t res;
    epcal_result_t out_reg;
    logic          out_valid_reg, out_valid_next;

    epcal_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_valid),
        .seconds_in (epoch_seconds),
        .idle       (idle),
        .res_valid  (res_valid),
        .res_ack    (load),
        .res        (res)
    );

    assign in_ready = idle;

    // Load when the output register is empty or drains this cycle.
    assign load = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign year_count   = out_reg.year_count;
    assign month        = out_reg.month;
    assign day_of_month = out_reg.day_of_month;
    assign hour         = out_reg.hour;
    assign minute       = out_reg.minute;
    assign second       = out_reg.second;
    assign weekday      = out_reg.weekday;

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `ASSERT_IMPLY(a_date_range, clk, rst_n, out_valid,
        month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
        && year_count >= YEAR_OFFSET && year_count <= YEAR_LIMIT)
    `ASSERT_IMPLY(a_time_range, clk, rst_n, out_valid,
        hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 && weekday <= 3'd6)

endmodule

[design/epcal_sub.sv]
module epcal_sub
    import epcal_pkg::*;
(
    input  logic [TW-1:0] a,
    input  logic [TW-1:0] b,
    output logic          ge,
    output logic [TW-1:0] diff
);

    logic [TW:0] wide;

    // Borrow out of the subtract gives the compare.
    assign wide = {1'b0, a} - {1'b0, b};
    assign ge   = ~wide[TW];
    assign diff = wide[TW-1:0];

endmodule

[design/epcal_ctrl.sv]
module epcal_ctrl
    import epcal_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [TW-1:0] seconds_in,
    output logic          idle,
    output logic          res_valid,
    input  logic          res_ack,
    output epcal_result_t res
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_YEAR  = 7'b0000010,
        S_MONTH = 7'b0000100,
        S_DAY   = 7'b0001000,
        S_HOUR  = 7'b0010000,
        S_MIN   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [TW-1:0] t_reg, t_next;
    logic [6:0]    yr_reg, yr_next;
    logic [3:0]    mon_reg, mon_next;
    logic [2:0]    k_reg, k_next;
    logic [4:0]    day_reg, day_next;
    logic [4:0]    hour_reg, hour_next;
    logic [5:0]    min_reg, min_next;

    logic [TW-1:0] op_b;
    logic [TW-1:0] diff;
    logic          ge;
    logic          leap;
    logic [TW-1:0] year_len;
    logic [4:0]    day_num;

    assign leap     = (yr_reg[1:0] == 2'b00);
    assign year_len = leap ? SECS_LEAP_YEAR : SECS_YEAR;

    epcal_sub u_sub (
        .a    (t_reg),
        .b    (op_b),
        .ge   (ge),
        .diff (diff)
    );

    always_comb
    begin
        unique case (state_reg)
            S_YEAR:  op_b = year_len;
            S_MONTH: op_b = month_secs(mon_reg, leap);
            S_DAY:   op_b = SECS_PER_DAY << k_reg;
            S_HOUR:  op_b = SECS_PER_HOUR << k_reg;
            S_MIN:   op_b = SECS_PER_MIN << k_reg;
            default: op_b = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        yr_next    = yr_reg;
        mon_next   = mon_reg;
        k_next     = k_reg;
        day_next   = day_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    t_next     = seconds_in;
                    yr_next    = YEAR_OFFSET;
                    mon_next   = 4'd1;
                    state_next = S_YEAR;
                end
            end
            S_YEAR:
            begin
                if (yr_reg < YEAR_LIMIT)
                begin
                    if (ge)
                    begin
                        t_next  = diff;
                        yr_next = yr_reg + 7'd1;
                    end
                    else
                    begin
                        state_next = S_MONTH;
                    end
                end
                else
                begin
                    // Saturate to the last second of the final year.
                    if (ge)
                    begin
                        t_next = year_len - TW'(1);
                    end
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                if (mon_reg < LAST_MONTH && ge)
                begin
                    t_next   = diff;
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    k_next     = DAY_TOP_BIT;
                    day_next   = '0;
                    state_next = S_DAY;
                end
            end
            S_DAY:
            begin
                if (ge)
                begin
                    t_next         = diff;
                    day_next[k_reg] = 1'b1;
                end
                if (k_reg == 3'd0)
                begin
                    k_next     = HOUR_TOP_BIT;
                    hour_next  = '0;
                    state_next = S_HOUR;
                end
                else
                begin
                    k_next = k_reg - 3'd1;
                end
            end
            S_HOUR:
            begin
                if (ge)
                begin
                    t_next           = diff;
                    hour_next[k_reg] = 1'b1;
                end
                if (k_reg == 3'd0)
                begin
                    k_next     = MIN_TOP_BIT;
                    min_next   = '0;
                    state_next = S_MIN;
                end
                else
                begin
                    k_next = k_reg - 3'd1;
                end
            end
            S_MIN:
            begin
                if (ge)
                begin
                    t_next          = diff;
                    min_next[k_reg] = 1'b1;
                end
                if (k_reg == 3'd0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next = k_reg - 3'd1;
                end
            end
            S_DONE:
            begin
                if (res_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        yr_reg   <= yr_next;
        mon_reg  <= mon_next;
        k_reg    <= k_next;
        day_reg  <= day_next;
        hour_reg <= hour_next;
        min_reg  <= min_next;
    end

    assign day_num   = day_reg + 5'd1;
    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    assign res.year_count   = yr_reg;
    assign res.month        = mon_reg;
    assign res.day_of_month = day_num;
    assign res.hour         = hour_reg;
    assign res.minute       = min_reg;
    assign res.second       = t_reg[5:0];
    assign res.weekday      = mod7(day_num);

endmodule
